[hw/rtl/psm_pkg.sv]
package psm_pkg;

  // Field and datapath widths
  localparam int COORD_W  = 24;
  localparam int EDGE_W   = COORD_W + 1;
  localparam int PROD_W   = 2 * EDGE_W;
  localparam int CROSS_W  = PROD_W + 1;
  localparam int POS_W    = 6;
  localparam int MAG_W    = 31;
  localparam int SQ_W     = 2 * MAG_W;
  localparam int SUM_W    = 64;
  localparam int ROOT_W   = 32;
  localparam int REM_W    = ROOT_W + 2;
  localparam int QUO_W    = 31;
  localparam int DIV_STEPS = QUO_W - 1;
  localparam int NORM_W   = 32;
  localparam int NP_W     = NORM_W + COORD_W;
  localparam int PL_W     = 58;
  localparam int DOT_W    = 59;
  localparam int SPLIT    = 29;
  localparam int ACC_W    = 84;
  localparam int ENTRY_W  = 48;
  localparam int COL_W    = 2;

  // Normalized magnitude sits in [2^30, 2^31)
  localparam logic [POS_W-1:0] NORM_MSB = POS_W'(MAG_W - 1);
  localparam logic [COL_W-1:0] LAST_COL = 2'd3;
  localparam logic [COL_W-1:0] COL0     = 2'd0;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t p0_x;
    coord_t p0_y;
    coord_t p0_z;
    coord_t p1_x;
    coord_t p1_y;
    coord_t p1_z;
    coord_t p2_x;
    coord_t p2_y;
    coord_t p2_z;
    coord_t light_x;
    coord_t light_y;
    coord_t light_z;
  } psm_in_t;

  typedef struct packed {
    logic [COL_W-1:0]          column_index;
    logic signed [ENTRY_W-1:0] row0_entry;
    logic signed [ENTRY_W-1:0] row1_entry;
    logic signed [ENTRY_W-1:0] row2_entry;
    logic signed [ENTRY_W-1:0] row3_entry;
    logic                      degenerate;
    logic                      last_column;
  } psm_out_t;

  // Data that rides along the normalize / sqrt / divide pipeline
  typedef struct packed {
    logic [2:0] neg;
    logic       degen;
    logic       lw;
    coord_t     p2x;
    coord_t     p2y;
    coord_t     p2z;
    coord_t     lx;
    coord_t     ly;
    coord_t     lz;
  } psm_side_t;

  typedef logic [2:0][MAG_W-1:0] mag3_t;
  typedef logic [2:0][QUO_W-1:0] quo3_t;

endpackage

[hw/rtl/planar_shadow_matrix.sv]
// Channel    Handshake                 Payload
// --------   -----------------------   -------------------------------
// command    start / busy              item      (psm_in_t)
// result     result_valid (strobe)     result    (psm_out_t)
// config     cfg_we                    cfg_wdata (light_w)
//
// A transaction is taken when start is high and busy is low; busy then stays
// high until the entry gap counter runs out, a spacing that matches the column
// sequencer, which sends four columns, one per cycle.
// The 32-stage square root and 31-stage divide dominate the latency from
// acceptance to the first column. rst is synchronous; light_w resets to 1.
// The result strobe cannot be held off; the four columns leave back to back.
module planar_shadow_matrix #(
  parameter int COORD_FRAC_BITS = 12
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  psm_pkg::psm_in_t  item,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  output logic              result_valid,
  output psm_pkg::psm_out_t result
);
  import psm_pkg::*;

  // Light w register
  logic light_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      light_w <= 1'b1;
    end else if (cfg_we) begin
      light_w <= cfg_wdata;
    end
  end

  // Entry spacing: gap counter that holds busy after each accepted transaction
  logic       accept;
  logic [1:0] gap;

  assign accept = start && !busy;
  assign busy   = (gap != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      gap <= '0;
    end else if (accept) begin
      gap <= 2'd3;
    end else if (gap != 2'd0) begin
      gap <= gap - 1'b1;
    end
  end

  // Normalize front end
  logic      f_valid;
  logic [63:0] f_sum;
  mag3_t     f_u;
  psm_side_t f_side;

  psm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .in_item  (item),
    .light_w  (light_w),
    .out_valid(f_valid),
    .out_sum  (f_sum),
    .out_u    (f_u),
    .out_side (f_side)
  );

  // Length
  logic      q_valid;
  logic [31:0] q_root;
  mag3_t     q_u;
  psm_side_t q_side;

  psm_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .in_valid (f_valid),
    .in_sum   (f_sum),
    .in_u     (f_u),
    .in_side  (f_side),
    .out_valid(q_valid),
    .out_root (q_root),
    .out_u    (q_u),
    .out_side (q_side)
  );

  // Unit normal magnitudes
  logic      d_valid;
  quo3_t     d_quo;
  psm_side_t d_side;

  psm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (q_valid),
    .in_len   (q_root),
    .in_u     (q_u),
    .in_side  (q_side),
    .out_valid(d_valid),
    .out_quo  (d_quo),
    .out_side (d_side)
  );

  // Plane, dot product and matrix columns
  psm_back #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d_valid),
    .in_quo    (d_quo),
    .in_side   (d_side),
    .out_valid (result_valid),
    .out_result(result)
  );

endmodule

[hw/rtl/psm_front.sv]
module psm_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  psm_pkg::psm_in_t  in_item,
  input  logic              light_w,
  output logic              out_valid,
  output logic [63:0]       out_sum,
  output psm_pkg::mag3_t    out_u,
  output psm_pkg::psm_side_t out_side
);
  import psm_pkg::*;

  // Valid chain, stages 1..8
  logic [8:1] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[7:1], in_valid};
    end
  end

  // Stage 1: edge vectors
  logic signed [EDGE_W-1:0] v1 [3];
  logic signed [EDGE_W-1:0] v2 [3];
  psm_side_t s1_side;

  always_ff @(posedge clk) begin
    v1[0] <= EDGE_W'(in_item.p0_x) - EDGE_W'(in_item.p1_x);
    v1[1] <= EDGE_W'(in_item.p0_y) - EDGE_W'(in_item.p1_y);
    v1[2] <= EDGE_W'(in_item.p0_z) - EDGE_W'(in_item.p1_z);
    v2[0] <= EDGE_W'(in_item.p1_x) - EDGE_W'(in_item.p2_x);
    v2[1] <= EDGE_W'(in_item.p1_y) - EDGE_W'(in_item.p2_y);
    v2[2] <= EDGE_W'(in_item.p1_z) - EDGE_W'(in_item.p2_z);
    s1_side.neg   <= '0;
    s1_side.degen <= 1'b0;
    s1_side.lw    <= light_w;
    s1_side.p2x   <= in_item.p2_x;
    s1_side.p2y   <= in_item.p2_y;
    s1_side.p2z   <= in_item.p2_z;
    s1_side.lx    <= in_item.light_x;
    s1_side.ly    <= in_item.light_y;
    s1_side.lz    <= in_item.light_z;
  end

  // Stage 2: cross product partial products
  logic signed [PROD_W-1:0] m [6];
  psm_side_t s2_side;

  always_ff @(posedge clk) begin
    m[0] <= v1[1] * v2[2];
    m[1] <= v1[2] * v2[1];
    m[2] <= v1[2] * v2[0];
    m[3] <= v1[0] * v2[2];
    m[4] <= v1[0] * v2[1];
    m[5] <= v1[1] * v2[0];
    s2_side <= s1_side;
  end

  // Stage 3: cross terms, split into sign and magnitude
  logic signed [CROSS_W-1:0] cr [3];
  logic [CROSS_W-1:0] s3_u [3];
  psm_side_t s3_side_next;
  psm_side_t s3_side;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cr[i] = CROSS_W'(m[2*i]) - CROSS_W'(m[2*i+1]);
    end
    s3_side_next     = s2_side;
    s3_side_next.neg = {cr[2][CROSS_W-1], cr[1][CROSS_W-1], cr[0][CROSS_W-1]};
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s3_u[i] <= cr[i][CROSS_W-1] ? CROSS_W'(-cr[i]) : CROSS_W'(cr[i]);
    end
    s3_side <= s3_side_next;
  end

  // Stage 4: largest magnitude
  logic [CROSS_W-1:0] mx_next;
  logic [CROSS_W-1:0] s4_mx;
  logic [CROSS_W-1:0] s4_u [3];
  psm_side_t s4_side;

  always_comb begin
    mx_next = s3_u[0];
    if (s3_u[1] > mx_next) mx_next = s3_u[1];
    if (s3_u[2] > mx_next) mx_next = s3_u[2];
  end

  always_ff @(posedge clk) begin
    s4_mx   <= mx_next;
    s4_u    <= s3_u;
    s4_side <= s3_side;
  end

  // Stage 5: leading one of the largest magnitude
  logic [POS_W-1:0] pos_next;
  logic [POS_W-1:0] s5_pos;
  logic [CROSS_W-1:0] s5_u [3];
  psm_side_t s5_side_next;
  psm_side_t s5_side;

  always_comb begin
    pos_next = '0;
    for (int i = 0; i < CROSS_W; i++) begin
      if (s4_mx[i]) pos_next = POS_W'(i);
    end
    s5_side_next       = s4_side;
    s5_side_next.degen = (s4_mx == '0);
  end

  always_ff @(posedge clk) begin
    s5_pos  <= pos_next;
    s5_u    <= s4_u;
    s5_side <= s5_side_next;
  end

  // Stage 6: common shift into [2^30, 2^31), right shift truncates
  logic [CROSS_W-1:0] sh [3];
  mag3_t s6_u;
  psm_side_t s6_side;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (s5_pos >= NORM_MSB) sh[i] = s5_u[i] >> (s5_pos - NORM_MSB);
      else                    sh[i] = s5_u[i] << (NORM_MSB - s5_pos);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s6_u[i] <= sh[i][MAG_W-1:0];
    end
    s6_side <= s5_side;
  end

  // Stage 7: squares
  logic [SQ_W-1:0] sq [3];
  mag3_t s7_u;
  psm_side_t s7_side;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq[i] <= s6_u[i] * s6_u[i];
    end
    s7_u    <= s6_u;
    s7_side <= s6_side;
  end

  // Stage 8: sum of squares
  always_ff @(posedge clk) begin
    out_sum  <= SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
    out_u    <= s7_u;
    out_side <= s7_side;
  end

  assign out_valid = vld[8];

endmodule

[hw/rtl/psm_sqrt.sv]
module psm_sqrt (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [63:0]        in_sum,
  input  psm_pkg::mag3_t     in_u,
  input  psm_pkg::psm_side_t in_side,
  output logic               out_valid,
  output logic [31:0]        out_root,
  output psm_pkg::mag3_t     out_u,
  output psm_pkg::psm_side_t out_side
);
  import psm_pkg::*;

  // One root bit per stage, digit-by-digit restoring square root
  logic              vld  [ROOT_W];
  logic [REM_W-1:0]  rem  [ROOT_W];
  logic [ROOT_W-1:0] root [ROOT_W];
  logic [SUM_W-1:0]  xs   [ROOT_W];
  mag3_t             us   [ROOT_W];
  psm_side_t         sd   [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    logic              v_in;
    logic [REM_W-1:0]  r_in;
    logic [ROOT_W-1:0] q_in;
    logic [SUM_W-1:0]  x_in;
    mag3_t             u_in;
    psm_side_t         s_in;
    logic [REM_W-1:0]  r_try;
    logic [REM_W-1:0]  trial;

    if (k == 0) begin : g_src
      assign v_in = in_valid;
      assign r_in = '0;
      assign q_in = '0;
      assign x_in = in_sum;
      assign u_in = in_u;
      assign s_in = in_side;
    end else begin : g_src
      assign v_in = vld[k-1];
      assign r_in = rem[k-1];
      assign q_in = root[k-1];
      assign x_in = xs[k-1];
      assign u_in = us[k-1];
      assign s_in = sd[k-1];
    end

    assign r_try = {r_in[REM_W-3:0], x_in[SUM_W-1 -: 2]};
    assign trial = {q_in, 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (r_try >= trial) begin
        rem[k]  <= r_try - trial;
        root[k] <= {q_in[ROOT_W-2:0], 1'b1};
      end else begin
        rem[k]  <= r_try;
        root[k] <= {q_in[ROOT_W-2:0], 1'b0};
      end
      xs[k] <= x_in << 2;
      us[k] <= u_in;
      sd[k] <= s_in;
    end
  end

  assign out_valid = vld[ROOT_W-1];
  assign out_root  = root[ROOT_W-1];
  assign out_u     = us[ROOT_W-1];
  assign out_side  = sd[ROOT_W-1];

endmodule

[hw/rtl/psm_div.sv]
module psm_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [31:0]        in_len,
  input  psm_pkg::mag3_t     in_u,
  input  psm_pkg::psm_side_t in_side,
  output logic               out_valid,
  output psm_pkg::quo3_t     out_quo,
  output psm_pkg::psm_side_t out_side
);
  import psm_pkg::*;

  // Three restoring dividers in lockstep: u * 2^30 / len, one bit a stage.
  // The first stage settles the integer bit, the rest shift in zeros.
  logic              vld [DIV_STEPS+1];
  logic [ROOT_W-1:0] len [DIV_STEPS+1];
  logic [ROOT_W-1:0] rem [DIV_STEPS+1][3];
  quo3_t             quo [DIV_STEPS+1];
  psm_side_t         sd  [DIV_STEPS+1];

  // Integer bit
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (ROOT_W'(in_u[i]) >= in_len) begin
        rem[0][i] <= ROOT_W'(in_u[i]) - in_len;
        quo[0][i] <= QUO_W'(1);
      end else begin
        rem[0][i] <= ROOT_W'(in_u[i]);
        quo[0][i] <= '0;
      end
    end
    len[0] <= in_len;
    sd[0]  <= in_side;
  end

  // Fraction bits
  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
    logic [ROOT_W:0] r2 [3];

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        r2[i] = {rem[k-1][i], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      for (int i = 0; i < 3; i++) begin
        if (r2[i] >= {1'b0, len[k-1]}) begin
          rem[k][i] <= ROOT_W'(r2[i] - {1'b0, len[k-1]});
          quo[k][i] <= {quo[k-1][i][QUO_W-2:0], 1'b1};
        end else begin
          rem[k][i] <= r2[i][ROOT_W-1:0];
          quo[k][i] <= {quo[k-1][i][QUO_W-2:0], 1'b0};
        end
      end
      len[k] <= len[k-1];
      sd[k]  <= sd[k-1];
    end
  end

  assign out_valid = vld[DIV_STEPS];
  assign out_quo   = quo[DIV_STEPS];
  assign out_side  = sd[DIV_STEPS];

endmodule

[hw/rtl/psm_back.sv]
module psm_back #(
  parameter int COORD_FRAC_BITS = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  psm_pkg::quo3_t     in_quo,
  input  psm_pkg::psm_side_t in_side,
  output logic               out_valid,
  output psm_pkg::psm_out_t  out_result
);
  import psm_pkg::*;

  localparam int OUT_SH = 2 * COORD_FRAC_BITS - 2;

  // Stage A: signed unit normal, Q1.30
  logic                     sa_valid;
  logic signed [NORM_W-1:0] sa_n [3];
  psm_side_t                sa_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      sa_valid <= 1'b0;
    end else begin
      sa_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sa_n[i] <= in_side.neg[i] ? -NORM_W'(in_quo[i]) : NORM_W'(in_quo[i]);
    end
    sa_side <= in_side;
  end

  // Stage B: normal times third point and times light
  logic                   sb_valid;
  logic signed [NP_W-1:0] pp [3];
  logic signed [NP_W-1:0] lp [3];
  logic signed [NORM_W-1:0] sb_n [3];
  psm_side_t              sb_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      sb_valid <= 1'b0;
    end else begin
      sb_valid <= sa_valid;
    end
  end

  always_ff @(posedge clk) begin
    pp[0] <= sa_n[0] * sa_side.p2x;
    pp[1] <= sa_n[1] * sa_side.p2y;
    pp[2] <= sa_n[2] * sa_side.p2z;
    lp[0] <= sa_n[0] * sa_side.lx;
    lp[1] <= sa_n[1] * sa_side.ly;
    lp[2] <= sa_n[2] * sa_side.lz;
    sb_n    <= sa_n;
    sb_side <= sa_side;
  end

  // Stage C: plane offset and light dot product, held for the column run
  logic signed [PL_W-1:0]  psum;
  logic signed [DOT_W-1:0] lsum;
  logic signed [NORM_W-1:0] h_n [3];
  logic signed [PL_W-1:0]  h_d;
  logic signed [DOT_W-1:0] h_dot;
  coord_t                  h_l [3];
  logic                    h_lw;
  logic                    h_degen;

  always_comb begin
    psum = PL_W'(pp[0]) + PL_W'(pp[1]) + PL_W'(pp[2]);
    lsum = DOT_W'(lp[0]) + DOT_W'(lp[1]) + DOT_W'(lp[2]);
  end

  always_ff @(posedge clk) begin
    if (sb_valid) begin
      h_n     <= sb_n;
      h_d     <= -psum;
      h_dot   <= sb_side.lw ? lsum - DOT_W'(psum) : lsum;
      h_l[0]  <= sb_side.lx;
      h_l[1]  <= sb_side.ly;
      h_l[2]  <= sb_side.lz;
      h_lw    <= sb_side.lw;
      h_degen <= sb_side.degen;
    end
  end

  // Column sequencer: four columns per transaction
  logic             active;
  logic [COL_W-1:0] col;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      col    <= '0;
    end else if (sb_valid) begin
      active <= 1'b1;
      col    <= '0;
    end else if (active) begin
      if (col == LAST_COL) active <= 1'b0;
      col <= col + 1'b1;
    end
  end

  // Stage D: split products of light row and plane column
  logic signed [PL_W-1:0] pl_c;
  logic                   sd_valid;
  logic [COL_W-1:0]       sd_col;
  logic                   sd_degen;
  logic signed [COORD_W+SPLIT:0]      plo [3];
  logic signed [COORD_W+PL_W-SPLIT-1:0] phi [3];
  logic signed [PL_W-1:0]  sd_pl3;
  logic signed [DOT_W-1:0] sd_dot;

  always_comb begin
    case (col)
      2'd0:    pl_c = PL_W'(h_n[0]) <<< COORD_FRAC_BITS;
      2'd1:    pl_c = PL_W'(h_n[1]) <<< COORD_FRAC_BITS;
      2'd2:    pl_c = PL_W'(h_n[2]) <<< COORD_FRAC_BITS;
      default: pl_c = h_d;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sd_valid <= 1'b0;
    end else begin
      sd_valid <= active;
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      plo[r] <= h_l[r] * $signed({1'b0, pl_c[SPLIT-1:0]});
      phi[r] <= h_l[r] * $signed(pl_c[PL_W-1:SPLIT]);
    end
    sd_pl3   <= h_lw ? pl_c : '0;
    sd_dot   <= h_dot;
    sd_col   <= col;
    sd_degen <= h_degen;
  end

  // Stage E: full entries at 30+2F fraction bits
  logic signed [ACC_W-1:0] prod [4];
  logic signed [ACC_W-1:0] acc [4];
  logic                    se_valid;
  logic [COL_W-1:0]        se_col;
  logic                    se_degen;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      prod[r] = (ACC_W'(phi[r]) <<< SPLIT) + ACC_W'(plo[r]);
    end
    prod[3] = ACC_W'(sd_pl3) <<< COORD_FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      se_valid <= 1'b0;
    end else begin
      se_valid <= sd_valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < 4; r++) begin
      if (sd_col == COL_W'(r)) acc[r] <= (ACC_W'(sd_dot) <<< COORD_FRAC_BITS) - prod[r];
      else                     acc[r] <= -prod[r];
    end
    se_col   <= sd_col;
    se_degen <= sd_degen;
  end

  // Stage F: truncate toward zero to 32 fraction bits and saturate
  function automatic logic signed [ENTRY_W-1:0] to_entry(logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] b;
    logic signed [ACC_W-1:0] s;
    b = a[ACC_W-1] ? a + {{(ACC_W-OUT_SH){1'b0}}, {OUT_SH{1'b1}}} : a;
    s = b >>> OUT_SH;
    if ((&s[ACC_W-1:ENTRY_W-1]) || !(|s[ACC_W-1:ENTRY_W-1])) begin
      return s[ENTRY_W-1:0];
    end else if (s[ACC_W-1]) begin
      return {1'b1, {(ENTRY_W-1){1'b0}}};
    end else begin
      return {1'b0, {(ENTRY_W-1){1'b1}}};
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= se_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_result.column_index <= se_col;
    out_result.row0_entry   <= se_degen ? '0 : to_entry(acc[0]);
    out_result.row1_entry   <= se_degen ? '0 : to_entry(acc[1]);
    out_result.row2_entry   <= se_degen ? '0 : to_entry(acc[2]);
    out_result.row3_entry   <= se_degen ? '0 : to_entry(acc[3]);
    out_result.degenerate   <= se_degen;
    out_result.last_column  <= (se_col == LAST_COL);
  end

endmodule

[hw/rtl/psm_checker.sv]
module psm_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              result_valid,
  input psm_pkg::psm_out_t result
);
  import psm_pkg::*;

  // Busy stays high through the gap window after a transaction is taken
  a_busy_gap: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy ##1 busy ##1 busy)
    else $error("busy window too short");

  // Columns of one run come on back-to-back cycles
  a_run_contig: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last_column |=> result_valid &&
      result.column_index == $past(result.column_index) + 2'd1)
    else $error("column run broken");

  // A run starts at column zero, only after the previous run ended
  a_run_start: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.column_index == COL0 |->
      !$past(result_valid) || $past(result.last_column))
    else $error("column zero inside a run");

  // Degenerate planes give all-zero entries
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.degenerate |->
      result.row0_entry == '0 && result.row1_entry == '0 &&
      result.row2_entry == '0 && result.row3_entry == '0)
    else $error("degenerate column not zero");

endmodule

bind planar_shadow_matrix psm_checker u_psm_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .result_valid(result_valid),
  .result      (result)
);
